// ===== sv/bsc_pkg.sv =====
// Package for the barometric sensor compensation block.
// Holds request and result structs, register indexes and constants.
`timescale 1ns / 1ps
package bsc_pkg;
  typedef struct packed {
    logic        operation;
    logic [18:0] raw_reading;
    logic [1:0]  oversampling;
  } req_t;

  typedef struct packed {
    logic signed [31:0] compensated_value;
    logic               value_kind;
    logic               divide_error;
  } res_t;

  localparam logic [2:0] REG_AC1 = 3'd0;
  localparam logic [2:0] REG_AC2 = 3'd1;
  localparam logic [2:0] REG_AC3 = 3'd2;
  localparam logic [2:0] REG_AC4 = 3'd3;
  localparam logic [2:0] REG_AC56 = 3'd4;
  localparam logic [2:0] REG_B1 = 3'd5;
  localparam logic [2:0] REG_B2 = 3'd6;
  localparam logic [2:0] REG_MCMD = 3'd7;

  localparam logic [5:0] MUL_BITS = 6'd32;
endpackage

// ===== sv/baro_sensor_compensation_top.sv =====
// Top level of the barometric sensor compensation block.
// Depends on bsc_pkg, bsc_mul and bsc_div.
`timescale 1ns / 1ps
// One request is handled at a time. A temperature request runs two multiplies or divides and a
// pressure request eleven, each done in 32 iterations by the bit-serial multiplier or divider
// and issued one after another by the sequencer. A zero divisor ends the request early. The
// result sits in an output register; a new request can be taken in the cycle after the result
// is accepted.
module baro_sensor_compensation_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsc_pkg::req_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bsc_pkg::res_t       out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import bsc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0, S_T1 = 5'd1, S_T2 = 5'd2, S_T3 = 5'd3,
    S_P1 = 5'd4, S_P2 = 5'd5, S_P3 = 5'd6, S_P4 = 5'd7, S_P5 = 5'd8, S_P6 = 5'd9,
    S_P7 = 5'd10, S_P8 = 5'd11, S_P9 = 5'd12, S_P10 = 5'd13, S_P11 = 5'd14,
    S_P12 = 5'd15, S_DONE = 5'd16, S_WAIT = 5'd17;

  logic [15:0] ac1, ac2, ac3, ac4, b1, b2;
  logic [31:0] ac56, mcmd, b5;
  logic [4:0] state;
  logic wait_mul;
  req_t req;
  logic [31:0] r0, r1, r2, r3, r4;
  logic m_start, m_done, d_start, d_done;
  logic [31:0] ma, mb, mp, dn, dd, dq;
  logic neg, err;
  logic [31:0] val;

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction
  function automatic logic [31:0] neg32(input logic [31:0] v);
    return (~v) + 32'd1;
  endfunction

  bsc_mul u_mul (.clk, .rst, .start(m_start), .a(ma), .b(mb), .done(m_done), .p(mp));
  bsc_div u_div (.clk, .rst, .start(d_start), .n(dn), .d(dd), .done(d_done), .q(dq));

  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    m_start <= 1'b0;
    d_start <= 1'b0;
    if (rst) begin
      ac1 <= 16'd408; ac2 <= 16'hFFB8; ac3 <= 16'hC7D1; ac4 <= 16'd32741;
      ac56 <= 32'd2146785905; b1 <= 16'd6190; b2 <= 16'd4; mcmd <= 32'd3724086068;
      b5 <= '0;
      state <= S_IDLE;
      out_valid <= 1'b0;
      wait_mul <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AC1: ac1 <= cfg_data[15:0];
          REG_AC2: ac2 <= cfg_data[15:0];
          REG_AC3: ac3 <= cfg_data[15:0];
          REG_AC4: ac4 <= cfg_data[15:0];
          REG_AC56: ac56 <= cfg_data;
          REG_B1: b1 <= cfg_data[15:0];
          REG_B2: b2 <= cfg_data[15:0];
          REG_MCMD: mcmd <= cfg_data;
          default: ;
        endcase
      end
      if (wait_mul) begin
        if (m_done || d_done) wait_mul <= 1'b0;
      end else begin
        unique case (state)
          S_IDLE: if (in_valid && !in_stall) begin
            req <= in_data;
            err <= 1'b0;
            if (in_data.operation) begin
              r0 <= b5 - 32'd4000;
              ma <= b5 - 32'd4000; mb <= b5 - 32'd4000;
              m_start <= 1'b1; wait_mul <= 1'b1;
              state <= S_P1;
            end else begin
              ma <= {16'd0, in_data.raw_reading[15:0]} - {16'd0, ac56[15:0]};
              mb <= {16'd0, ac56[31:16]};
              m_start <= 1'b1; wait_mul <= 1'b1;
              state <= S_T1;
            end
          end
          S_T1: begin
            r1 <= asr(mp, 5'd15);
            if (asr(mp, 5'd15) + sx(mcmd[15:0]) == 32'd0) begin
              err <= 1'b1; val <= '0; state <= S_DONE;
            end else begin
              r2 <= asr(mp, 5'd15) + sx(mcmd[15:0]);
              r3 <= {{5{mcmd[31]}}, mcmd[31:16], 11'd0};
              state <= S_T2;
            end
          end
          S_T2: begin
            neg <= r2[31] ^ r3[31];
            dn <= r3[31] ? neg32(r3) : r3;
            dd <= r2[31] ? neg32(r2) : r2;
            d_start <= 1'b1; wait_mul <= 1'b1;
            state <= S_T3;
          end
          S_T3: begin
            b5 <= r1 + (neg ? neg32(dq) : dq);
            val <= asr(r1 + (neg ? neg32(dq) : dq) + 32'd8, 5'd4);
            state <= S_DONE;
          end
          S_P1: begin
            r1 <= asr(mp, 5'd12);
            ma <= sx(b2); mb <= asr(mp, 5'd12);
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P2;
          end
          S_P2: begin
            r2 <= asr(mp, 5'd11);
            ma <= sx(ac2); mb <= r0;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P3;
          end
          S_P3: begin
            r2 <= ((((sx(ac1) << 2) + r2 + asr(mp, 5'd11)) << req.oversampling)
                   + 32'd2) >> 2;
            ma <= sx(ac3); mb <= r0;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P4;
          end
          S_P4: begin
            r3 <= asr(mp, 5'd13);
            ma <= sx(b1); mb <= r1;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P5;
          end
          S_P5: begin
            ma <= {16'd0, ac4};
            mb <= asr(r3 + asr(mp, 5'd16) + 32'd2, 5'd2) + 32'd32768;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P6;
          end
          S_P6: begin
            r3 <= mp >> 15;
            ma <= {13'd0, req.raw_reading} - r2;
            mb <= 32'd50000 >> req.oversampling;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P7;
          end
          S_P7: begin
            if (r3 == 32'd0) begin
              err <= 1'b1; val <= '0; state <= S_DONE;
            end else begin
              neg <= mp[31];
              dn <= mp[31] ? mp : (mp << 1);
              dd <= r3;
              d_start <= 1'b1; wait_mul <= 1'b1; state <= S_P8;
            end
          end
          S_P8: begin
            r4 <= neg ? (dq << 1) : dq;
            ma <= asr(neg ? (dq << 1) : dq, 5'd8);
            mb <= asr(neg ? (dq << 1) : dq, 5'd8);
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P9;
          end
          S_P9: begin
            ma <= mp; mb <= 32'd3038;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P10;
          end
          S_P10: begin
            r1 <= asr(mp, 5'd16);
            ma <= 32'hFFFFE343; mb <= r4;
            m_start <= 1'b1; wait_mul <= 1'b1; state <= S_P11;
          end
          S_P11: begin
            r2 <= asr(mp, 5'd16);
            state <= S_P12;
          end
          S_P12: begin
            val <= r4 + asr(r1 + r2 + 32'd3791, 5'd4);
            state <= S_DONE;
          end
          S_DONE: begin
            out_data.compensated_value <= val;
            out_data.value_kind <= req.operation;
            out_data.divide_error <= err;
            out_valid <= 1'b1;
            state <= S_WAIT;
          end
          S_WAIT: if (!out_valid || !out_stall) state <= S_IDLE;
          default: state <= S_IDLE;
        endcase
      end
    end
  end
endmodule

// ===== sv/bsc_mul.sv =====
// Bit-serial 32 by 32 multiplier, low 32 bits of the product (mod 2^32).
// Uses bsc_pkg for the operand width.
`timescale 1ns / 1ps
module bsc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] p
);
  import bsc_pkg::*;
  logic [31:0] acc, mc, mp;
  logic [5:0] cnt;
  logic busy;
  assign p = acc;
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      acc <= '0;
      mc <= a;
      mp <= b;
    end else if (busy) begin
      if (mp[0]) acc <= acc + mc;
      mc <= mc << 1;
      mp <= mp >> 1;
      cnt <= cnt + 6'd1;
      if (cnt == MUL_BITS - 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/bsc_div.sv =====
// Restoring bit-serial unsigned 32 by 32 divider, one quotient bit a cycle.
// Uses bsc_pkg for the width.
`timescale 1ns / 1ps
module bsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] n,
  input  logic [31:0] d,
  output logic        done,
  output logic [31:0] q
);
  import bsc_pkg::*;
  logic [31:0] rem, dv, qq;
  logic [32:0] trial;
  logic [5:0] cnt;
  logic busy;
  assign q = qq;
  assign trial = {rem, qq[31]} - {1'b0, dv};
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      rem <= '0;
      qq <= n;
      dv <= d;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        qq <= {qq[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], qq[31]};
        qq <= {qq[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == MUL_BITS - 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
